FILE: src/bb3_pkg.sv
// shared types and constants of the 3x3 binomial blur stream
package bb3_pkg;

	// default line buffer depth (widest supported row)
	localparam int MAX_WIDTH_DEF = 2048;

	// result queue geometry
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	// one result beat
	typedef struct packed {
		logic [7:0]  blurred;
		logic [10:0] column;
		logic [15:0] row;
		logic        frame_end;
		logic        last_of_run;
	} res_t;

	// up to two results handed to the queue in one cycle, in order
	typedef struct packed {
		logic [1:0] cnt;
		res_t       first;
		res_t       second;
	} push_t;

endpackage

FILE: src/binomial_blur_3x3_stream_top.sv
// 3x3 binomial blur of a raster pixel stream, top level
//
//  channel   signals                                    beat carries
//  in        in_valid / in_stall                        mode, pixel_in
//  out       out_valid / out_stall                      blurred, out_column, out_row,
//                                                       frame_end, last_of_run
//  config    psel penable pwrite paddr pwdata prdata    frame_width (0x0), frame_height (0x4)
//
// One input beat per cycle while in_stall is low; results pass s1 and the queue.
// Input stage forms the horizontal sums and reads the line memory (two read ports),
// the s1 stage combines them and writes back; a second write of a row end is queued.
// Results collect in a four-entry queue, so in_stall depends only on registers.
// Reset clears counters, pixel history and queue; the line memory is not cleared.
module binomial_blur_3x3_stream_top #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input pixels
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  pixel_in,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  blurred,
	output logic [10:0] out_column,
	output logic [15:0] out_row,
	output logic        frame_end,
	output logic        last_of_run,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LW        = 21;
	localparam int WLAST_RST = ((MAX_WIDTH < 2048) ? MAX_WIDTH : 2048) - 1;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// configuration registers
	logic [11:0]   frame_width_q;
	logic [15:0]   frame_height_q;
	logic [AW-1:0] wlast_q;
	logic          cfg_we;
	logic [11:0]   wr_w;
	logic [AW-1:0] wlast_new;
	logic [15:0]   eff_h;

	// stream state
	logic [AW-1:0] col_q;
	logic [15:0]   row_q;
	logic [7:0]    prev_pix_q;
	logic [8:0]    prev_pair_q;

	// input stage
	logic          accept;
	logic [7:0]    pix;
	logic          last;
	logic          row_ge;
	logic [8:0]    pair;
	logic [8:0]    new_pair;
	logic [9:0]    h_a;
	logic [9:0]    h_b;
	logic [AW-1:0] ra_a;
	logic [AW-1:0] ra_b;
	logic          fhit_s_a;
	logic          fhit_p_a;
	logic          fhit_s_b;
	logic          fhit_p_b;

	// line memory: {horizontal sum of row above, partial vertical sum}
	logic [LW-1:0] line_mem [MAX_WIDTH];
	logic [LW-1:0] rda_mem_s1;
	logic [LW-1:0] rdb_mem_s1;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [LW-1:0] mem_wd;

	// s1 stage
	logic          s1_valid;
	logic [AW-1:0] col_s1;
	logic [15:0]   row_s1;
	logic          zrow_s1;
	logic          has_a_s1;
	logic          has_b_s1;
	logic          fend_a_s1;
	logic          fend_b_s1;
	logic [9:0]    ha_s1;
	logic [9:0]    hb_s1;
	logic          fwd_a_s1;
	logic          fwd_b_s1;
	logic [LW-1:0] fwd_a_data_s1;
	logic [LW-1:0] fwd_b_data_s1;
	logic [LW-1:0] rd_a;
	logic [LW-1:0] rd_b;
	logic [10:0]   t_a;
	logic [10:0]   t_b;
	logic [7:0]    v_a;
	logic [7:0]    v_b;
	logic [LW-1:0] wd_a;
	logic [LW-1:0] wd_b;
	logic [1:0]    n_s1;
	logic          s1_go;
	logic          s1_we;
	logic [AW-1:0] s1_wa;
	logic [LW-1:0] s1_wd;

	// queued second write of a row end
	logic          pend_valid_q;
	logic [AW-1:0] pend_addr_q;
	logic [LW-1:0] pend_data_q;
	logic          pend_we;

	// result queue
	bb3_pkg::res_t                res_a;
	bb3_pkg::res_t                res_b;
	bb3_pkg::push_t               push;
	bb3_pkg::res_t                head;
	logic [bb3_pkg::OUTQ_CW-1:0]  free;

	// new vertical sum: row above plus this row
	function automatic logic [10:0] vert_t(input logic [LW-1:0] rd, input logic [9:0] h);
		return 11'({1'b0, rd[20:11]} + {1'b0, h});
	endfunction

	// filtered value from partial sum and new vertical sum
	function automatic logic [7:0] blur_v(input logic [LW-1:0] rd, input logic [10:0] t);
		logic [11:0] s;
		s = {1'b0, rd[10:0]} + {1'b0, t};
		return s[11:4];
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign wr_w   = pwdata[11:0];

	always_comb begin
		if (wr_w == 12'd0) begin
			wlast_new = '0;
		end else if (32'(wr_w) > 32'(MAX_WIDTH)) begin
			wlast_new = AW'(MAX_WIDTH - 1);
		end else begin
			wlast_new = AW'(wr_w - 12'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 12'd2048;
			frame_height_q <= 16'd1;
			wlast_q        <= AW'(WLAST_RST);
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH: begin
					frame_width_q <= wr_w;
					wlast_q       <= wlast_new;
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= pwdata[15:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = {20'd0, frame_width_q};
			REG_FRAME_HEIGHT: prdata = {16'd0, frame_height_q};
		endcase
	end

	// input handshake
	assign in_stall = s1_valid && !s1_go;
	assign accept   = in_valid && !in_stall;

	// horizontal sums and row position
	assign eff_h    = (frame_height_q == 16'd0) ? 16'd1 : frame_height_q;
	assign pix      = mode ? 8'd0 : pixel_in;
	assign last     = (col_q >= wlast_q);
	assign row_ge   = (row_q >= eff_h);
	assign pair     = {1'b0, prev_pix_q} + {1'b0, pix};
	assign h_a      = {1'b0, prev_pair_q} + {1'b0, pair};
	assign new_pair = (col_q == '0) ? {1'b0, pix} : pair;
	assign h_b      = {1'b0, new_pair} + {2'b0, pix};
	assign ra_a     = (col_q == '0) ? '0 : col_q - AW'(1);
	assign ra_b     = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			prev_pix_q  <= '0;
			prev_pair_q <= '0;
		end else if (accept) begin
			prev_pix_q  <= pix;
			prev_pair_q <= new_pair;
			if (last) begin
				col_q <= '0;
				row_q <= row_ge ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// bypass of writes landing at the same edge as the read
	assign fhit_s_a = s1_we && (s1_wa == ra_a);
	assign fhit_p_a = pend_valid_q && (pend_addr_q == ra_a);
	assign fhit_s_b = s1_we && (s1_wa == ra_b);
	assign fhit_p_b = pend_valid_q && (pend_addr_q == ra_b);

	// s1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	// s1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1        <= col_q;
			row_s1        <= row_q - 16'd1;
			zrow_s1       <= (row_q == 16'd0);
			has_a_s1      <= (col_q != '0);
			has_b_s1      <= last;
			fend_a_s1     <= row_ge && (col_q > wlast_q);
			fend_b_s1     <= row_ge;
			ha_s1         <= h_a;
			hb_s1         <= h_b;
			fwd_a_s1      <= fhit_s_a || fhit_p_a;
			fwd_b_s1      <= fhit_s_b || fhit_p_b;
			fwd_a_data_s1 <= fhit_s_a ? s1_wd : pend_data_q;
			fwd_b_data_s1 <= fhit_s_b ? s1_wd : pend_data_q;
		end
	end

	// line memory, read on accept
	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			rda_mem_s1 <= line_mem[ra_a];
			rdb_mem_s1 <= line_mem[ra_b];
		end
	end

	// vertical combine; the first row starts from zero
	always_comb begin
		rd_a = fwd_a_s1 ? fwd_a_data_s1 : rda_mem_s1;
		rd_b = fwd_b_s1 ? fwd_b_data_s1 : rdb_mem_s1;
		if (zrow_s1) begin
			rd_a = '0;
			rd_b = '0;
		end
		t_a  = vert_t(rd_a, ha_s1);
		t_b  = vert_t(rd_b, hb_s1);
		v_a  = blur_v(rd_a, t_a);
		v_b  = blur_v(rd_b, t_b);
		wd_a = {ha_s1, t_a};
		wd_b = {hb_s1, t_b};
	end

	// s1 hands over when its results fit in the queue
	assign n_s1  = zrow_s1 ? 2'd0 : 2'({1'b0, has_a_s1} + {1'b0, has_b_s1});
	assign s1_go = s1_valid && (bb3_pkg::OUTQ_CW'(n_s1) <= free);
	assign s1_we = s1_go && (has_a_s1 || has_b_s1);
	assign s1_wa = has_a_s1 ? col_s1 - AW'(1) : col_s1;
	assign s1_wd = has_a_s1 ? wd_a : wd_b;

	// memory write port: s1 first, queued row-end write otherwise
	assign pend_we = pend_valid_q && !s1_we;
	assign mem_we  = s1_we || pend_we;
	assign mem_wa  = s1_we ? s1_wa : pend_addr_q;
	assign mem_wd  = s1_we ? s1_wd : pend_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (s1_go && has_a_s1 && has_b_s1) begin
			pend_valid_q <= 1'b1;
		end else if (pend_we) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_a_s1 && has_b_s1) begin
			pend_addr_q <= col_s1;
			pend_data_q <= wd_b;
		end
	end

	// result beats
	always_comb begin
		res_a.blurred     = v_a;
		res_a.column      = 11'(col_s1 - AW'(1));
		res_a.row         = row_s1;
		res_a.frame_end   = fend_a_s1;
		res_a.last_of_run = !has_b_s1;
		res_b.blurred     = v_b;
		res_b.column      = 11'(col_s1);
		res_b.row         = row_s1;
		res_b.frame_end   = fend_b_s1;
		res_b.last_of_run = 1'b1;
		push.cnt          = s1_go ? n_s1 : 2'd0;
		push.first        = has_a_s1 ? res_a : res_b;
		push.second       = res_b;
	end

	bb3_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.free      (free),
		.head      (head),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	assign blurred     = head.blurred;
	assign out_column  = head.column;
	assign out_row     = head.row;
	assign frame_end   = head.frame_end;
	assign last_of_run = head.last_of_run;

endmodule

FILE: src/bb3_outq.sv
// result queue: two results a cycle in at most, one out unless stalled
module bb3_outq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bb3_pkg::push_t                   push,
	output logic [bb3_pkg::OUTQ_CW-1:0]      free,
	output bb3_pkg::res_t                    head,
	output logic                             out_valid,
	input  logic                             out_stall
);

	bb3_pkg::res_t                  ent_q [bb3_pkg::OUTQ_DEPTH];
	logic [bb3_pkg::OUTQ_AW-1:0]    wr_ptr_q;
	logic [bb3_pkg::OUTQ_AW-1:0]    rd_ptr_q;
	logic [bb3_pkg::OUTQ_CW-1:0]    count_q;
	logic                           pop;
	logic [bb3_pkg::OUTQ_AW-1:0]    wr_next;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign free      = bb3_pkg::OUTQ_CW'(bb3_pkg::OUTQ_DEPTH) - count_q;
	assign head      = ent_q[rd_ptr_q];
	assign wr_next   = wr_ptr_q + bb3_pkg::OUTQ_AW'(1);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + bb3_pkg::OUTQ_AW'(push.cnt);
			count_q  <= count_q + bb3_pkg::OUTQ_CW'(push.cnt) - bb3_pkg::OUTQ_CW'(pop);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bb3_pkg::OUTQ_AW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			ent_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			ent_q[wr_next] <= push.second;
		end
	end

endmodule
